// ===== rtl/etc_pkg.sv =====
`default_nettype none

package etc_pkg;

   // default number of rotation cells
   localparam int CORDIC_STAGES_DEF = 16;
   localparam int ATAN_LEN          = 24;

   // field widths
   localparam int ANG_W  = 16;
   localparam int SC_W   = 16;
   localparam int OUT_W  = 19;

   // internal widths
   localparam int RED_W  = 15;   // reduced angle, below 23040
   localparam int XY_W   = 31;   // cordic x/y, 28 fraction bits
   localparam int Z_W    = 29;   // residual angle, 2^-20 degree
   localparam int TRIG_W = 16;   // Q1.14 sine/cosine
   localparam int PAIR_W = 30;   // product of two Q1.14 values
   localparam int TRIP_W = 44;   // product of three Q1.14 values
   localparam int ENT_W  = 45;   // matrix entry, 42 fraction bits

   // axis slots
   localparam int AX_PITCH = 0;
   localparam int AX_ROLL  = 1;
   localparam int AX_YAW   = 2;

   // quadrant codes
   localparam logic [1:0] QD_0 = 2'd0;
   localparam logic [1:0] QD_1 = 2'd1;
   localparam logic [1:0] QD_2 = 2'd2;
   localparam logic [1:0] QD_3 = 2'd3;

   localparam logic [16:0] ANG_FULL  = 17'd23040;
   localparam logic [16:0] ANG_FULL2 = 17'd46080;
   localparam logic [16:0] ANG_FULL3 = 17'd69120;
   localparam logic [16:0] ANG_BIAS  = ANG_FULL2;

   localparam logic [RED_W-1:0] ANG_QUAD  = 15'd5760;
   localparam logic [RED_W-1:0] ANG_QUAD2 = 15'd11520;
   localparam logic [RED_W-1:0] ANG_QUAD3 = 15'd17280;

   localparam logic signed [XY_W-1:0]   GAIN_Q28 = 31'sd163008219;
   localparam logic signed [TRIG_W-1:0] TRIG_ONE = 16'sd16384;

   // atan(2^-i) in units of 2^-20 degree
   localparam logic [25:0] ATAN_TAB [ATAN_LEN] = '{
      26'd47185920, 26'd27855475, 26'd14718068, 26'd7471121,
      26'd3750058,  26'd1876857,  26'd938658,   26'd469357,
      26'd234682,   26'd117342,   26'd58671,    26'd29335,
      26'd14668,    26'd7334,     26'd3667,     26'd1833,
      26'd917,      26'd458,      26'd229,      26'd115,
      26'd57,       26'd29,       26'd14,       26'd7
   };

   typedef logic signed [XY_W-1:0]   xy_type;
   typedef logic signed [Z_W-1:0]    z_type;
   typedef logic signed [TRIG_W-1:0] trig_type;
   typedef logic signed [ENT_W-1:0]  ent_type;

   // state carried along the rotation chain, one slot per axis
   typedef struct packed {
      xy_type [2:0]          x;
      xy_type [2:0]          y;
      z_type  [2:0]          z;
      logic   [2:0][1:0]     quad;
      logic   [2:0][SC_W-1:0] scale;
   } rot_type;

   // unscaled matrix entries, column-major, with the scales alongside
   typedef struct packed {
      ent_type [8:0]          m;
      logic    [2:0][SC_W-1:0] scale;
   } col_type;

endpackage

`default_nettype wire

// ===== rtl/etc_angle_prep.sv =====
`default_nettype none

module etc_angle_prep
   import etc_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic [1:0]              en,
   input  wire logic [2:0][ANG_W-1:0]   angle,
   input  wire logic [2:0][SC_W-1:0]    scale,
   output rot_type                      rot
);

   logic [2:0][RED_W-1:0] red_ff, red_in;
   logic [2:0][SC_W-1:0]  scl_ff;
   rot_type               rot_ff, rot_in;

   // wrap into [0, 360) degrees
   always_comb begin
      logic [16:0] a_pos;
      for (int a = 0; a < 3; a++) begin
         a_pos = {angle[a][ANG_W-1], angle[a]} + ANG_BIAS;
         if (a_pos >= ANG_FULL3) begin
            red_in[a] = RED_W'(a_pos - ANG_FULL3);
         end else if (a_pos >= ANG_FULL2) begin
            red_in[a] = RED_W'(a_pos - ANG_FULL2);
         end else if (a_pos >= ANG_FULL) begin
            red_in[a] = RED_W'(a_pos - ANG_FULL);
         end else begin
            red_in[a] = RED_W'(a_pos);
         end
      end
   end

   // quadrant split and cordic seed
   always_comb begin
      logic [RED_W-1:0] res;
      rot_in       = '0;
      rot_in.scale = scl_ff;
      for (int a = 0; a < 3; a++) begin
         if (red_ff[a] >= ANG_QUAD3) begin
            rot_in.quad[a] = QD_3;
            res            = red_ff[a] - ANG_QUAD3;
         end else if (red_ff[a] >= ANG_QUAD2) begin
            rot_in.quad[a] = QD_2;
            res            = red_ff[a] - ANG_QUAD2;
         end else if (red_ff[a] >= ANG_QUAD) begin
            rot_in.quad[a] = QD_1;
            res            = red_ff[a] - ANG_QUAD;
         end else begin
            rot_in.quad[a] = QD_0;
            res            = red_ff[a];
         end
         rot_in.x[a] = GAIN_Q28;
         rot_in.y[a] = '0;
         rot_in.z[a] = {res, 14'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         red_ff <= red_in;
         scl_ff <= scale;
      end
      if (en[1]) begin
         rot_ff <= rot_in;
      end
   end

   assign rot = rot_ff;

endmodule

`default_nettype wire

// ===== rtl/etc_cordic_cell.sv =====
`default_nettype none

module etc_cordic_cell
   import etc_pkg::*;
#(
   parameter int STAGE = 0
)
(
   input  wire logic    clock,
   input  wire logic    en,
   input  wire rot_type d_in,
   output rot_type      d_out
);

   localparam z_type ATAN_STEP = z_type'({3'b0, ATAN_TAB[STAGE]});

   rot_type cell_ff, cell_in;

   always_comb begin
      xy_type x, y;
      z_type  z;
      cell_in = d_in;
      for (int a = 0; a < 3; a++) begin
         x = d_in.x[a];
         y = d_in.y[a];
         z = d_in.z[a];
         if (!z[Z_W-1]) begin
            cell_in.x[a] = x - (y >>> STAGE);
            cell_in.y[a] = y + (x >>> STAGE);
            cell_in.z[a] = z - ATAN_STEP;
         end else begin
            cell_in.x[a] = x + (y >>> STAGE);
            cell_in.y[a] = y - (x >>> STAGE);
            cell_in.z[a] = z + ATAN_STEP;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cell_ff <= cell_in;
      end
   end

   assign d_out = cell_ff;

endmodule

`default_nettype wire

// ===== rtl/etc_column.sv =====
`default_nettype none

module etc_column
   import etc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic [3:0] en,
   input  wire rot_type    rot,
   output col_type         col
);

   localparam int QW = XY_W - 13;
   localparam logic [XY_W:0]          RND_Q14 = (XY_W+1)'(8192);
   localparam logic signed [QW-1:0]   Q_ONE   = QW'(16384);

   function automatic trig_type round_q14(input xy_type v);
      logic        [XY_W:0] sum;
      logic signed [QW-1:0] q;
      sum = {v[XY_W-1], v} + RND_Q14;
      q   = sum[XY_W:14];
      if (q > Q_ONE) begin
         return TRIG_ONE;
      end else if (q < -Q_ONE) begin
         return -TRIG_ONE;
      end
      return q[TRIG_W-1:0];
   endfunction

   function automatic logic signed [PAIR_W-1:0] mul2(input trig_type a, input trig_type b);
      logic signed [2*TRIG_W-1:0] p;
      p = a * b;
      return p[PAIR_W-1:0];
   endfunction

   function automatic logic signed [TRIP_W-1:0] mul3(input logic signed [PAIR_W-1:0] a,
                                                     input trig_type b);
      logic signed [PAIR_W+TRIG_W-1:0] p;
      p = a * b;
      return p[TRIP_W-1:0];
   endfunction

   // stage 0: sine and cosine per axis
   trig_type [2:0]          s_ff, s_in, c_ff, c_in;
   logic [2:0][SC_W-1:0]    sc0_ff, sc1_ff, sc2_ff;

   always_comb begin
      trig_type s0, c0;
      for (int a = 0; a < 3; a++) begin
         s0 = round_q14(rot.y[a]);
         c0 = round_q14(rot.x[a]);
         unique case (rot.quad[a])
            QD_0: begin
               s_in[a] = s0;
               c_in[a] = c0;
            end
            QD_1: begin
               s_in[a] = c0;
               c_in[a] = -s0;
            end
            QD_2: begin
               s_in[a] = -s0;
               c_in[a] = -c0;
            end
            default: begin
               s_in[a] = -c0;
               c_in[a] = s0;
            end
         endcase
      end
   end

   // stage 1: pair products
   trig_type sp, cp, sr, cr, sy, cy;
   assign sp = s_ff[AX_PITCH];
   assign cp = c_ff[AX_PITCH];
   assign sr = s_ff[AX_ROLL];
   assign cr = c_ff[AX_ROLL];
   assign sy = s_ff[AX_YAW];
   assign cy = c_ff[AX_YAW];

   logic signed [PAIR_W-1:0] cycr_ff, sysp_ff, cysp_ff, sycr_ff, cysr_ff;
   logic signed [PAIR_W-1:0] sysr_ff, cpsr_ff, sycp_ff, cycp_ff, cpcr_ff;
   trig_type                 sp1_ff, sr1_ff, cr1_ff;

   // stage 2: triple products, pairs carried on
   logic signed [TRIP_W-1:0] t_sysp_sr_ff, t_cysp_sr_ff, t_sysp_cr_ff, t_cysp_cr_ff;
   logic signed [PAIR_W-1:0] cycr2_ff, sycr2_ff, cysr2_ff, sysr2_ff;
   logic signed [PAIR_W-1:0] cpsr2_ff, sycp2_ff, cycp2_ff, cpcr2_ff;
   trig_type                 sp2_ff;

   // stage 3: entries
   col_type col_ff, col_in;

   always_comb begin
      col_in.scale = sc2_ff;
      col_in.m[0]  = (ent_type'(cycr2_ff) <<< 14) - ent_type'(t_sysp_sr_ff);
      col_in.m[1]  = (ent_type'(sycr2_ff) <<< 14) + ent_type'(t_cysp_sr_ff);
      col_in.m[2]  = -(ent_type'(cpsr2_ff) <<< 14);
      col_in.m[3]  = -(ent_type'(sycp2_ff) <<< 14);
      col_in.m[4]  = ent_type'(cycp2_ff) <<< 14;
      col_in.m[5]  = ent_type'(sp2_ff) <<< 28;
      col_in.m[6]  = (ent_type'(cysr2_ff) <<< 14) + ent_type'(t_sysp_cr_ff);
      col_in.m[7]  = (ent_type'(sysr2_ff) <<< 14) - ent_type'(t_cysp_cr_ff);
      col_in.m[8]  = ent_type'(cpcr2_ff) <<< 14;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s_ff   <= s_in;
         c_ff   <= c_in;
         sc0_ff <= rot.scale;
      end
      if (en[1]) begin
         cycr_ff <= mul2(cy, cr);
         sysp_ff <= mul2(sy, sp);
         cysp_ff <= mul2(cy, sp);
         sycr_ff <= mul2(sy, cr);
         cysr_ff <= mul2(cy, sr);
         sysr_ff <= mul2(sy, sr);
         cpsr_ff <= mul2(cp, sr);
         sycp_ff <= mul2(sy, cp);
         cycp_ff <= mul2(cy, cp);
         cpcr_ff <= mul2(cp, cr);
         sp1_ff  <= sp;
         sr1_ff  <= sr;
         cr1_ff  <= cr;
         sc1_ff  <= sc0_ff;
      end
      if (en[2]) begin
         t_sysp_sr_ff <= mul3(sysp_ff, sr1_ff);
         t_cysp_sr_ff <= mul3(cysp_ff, sr1_ff);
         t_sysp_cr_ff <= mul3(sysp_ff, cr1_ff);
         t_cysp_cr_ff <= mul3(cysp_ff, cr1_ff);
         cycr2_ff     <= cycr_ff;
         sycr2_ff     <= sycr_ff;
         cysr2_ff     <= cysr_ff;
         sysr2_ff     <= sysr_ff;
         cpsr2_ff     <= cpsr_ff;
         sycp2_ff     <= sycp_ff;
         cycp2_ff     <= cycp_ff;
         cpcr2_ff     <= cpcr_ff;
         sp2_ff       <= sp1_ff;
         sc2_ff       <= sc1_ff;
      end
      if (en[3]) begin
         col_ff <= col_in;
      end
   end

   assign col = col_ff;

endmodule

`default_nettype wire

// ===== rtl/etc_scale.sv =====
`default_nettype none

module etc_scale
   import etc_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic [1:0]              en,
   input  wire ent_type                 entry,
   input  wire logic signed [SC_W-1:0]  scale,
   output logic signed [OUT_W-1:0]      result
);

   localparam int SPLIT  = 22;
   localparam int HI_W   = ENT_W - SPLIT;
   localparam int LO_W   = SPLIT + 1;
   localparam int PH_W   = HI_W + SC_W;
   localparam int PL_W   = LO_W + SC_W;
   localparam int ACC_W  = PH_W + SPLIT + 1;
   localparam int FRAC   = 40;
   localparam int V_W    = ACC_W - FRAC;
   localparam logic [ACC_W-1:0]      RND     = ACC_W'(64'd1 << (FRAC - 1));
   localparam logic signed [V_W-1:0] SAT_MAX = V_W'(131072);

   logic signed [PH_W-1:0]  p_hi_ff, p_hi_in;
   logic signed [PL_W-1:0]  p_lo_ff, p_lo_in;
   logic signed [OUT_W-1:0] res_ff, res_in;

   // split the entry so each product stays narrow
   always_comb begin
      logic signed [HI_W-1:0] m_hi;
      logic signed [LO_W-1:0] m_lo;
      m_hi    = entry[ENT_W-1:SPLIT];
      m_lo    = {1'b0, entry[SPLIT-1:0]};
      p_hi_in = m_hi * scale;
      p_lo_in = m_lo * scale;
   end

   always_comb begin
      logic        [ACC_W-1:0] sum;
      logic signed [V_W-1:0]   v;
      sum = (ACC_W'(p_hi_ff) << SPLIT) + ACC_W'(p_lo_ff) + RND;
      v   = sum[ACC_W-1:FRAC];
      if (v > SAT_MAX) begin
         res_in = OUT_W'(SAT_MAX);
      end else if (v < -SAT_MAX) begin
         res_in = OUT_W'(-SAT_MAX);
      end else begin
         res_in = v[OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         p_hi_ff <= p_hi_in;
         p_lo_ff <= p_lo_in;
      end
      if (en[1]) begin
         res_ff <= res_in;
      end
   end

   assign result = res_ff;

endmodule

`default_nettype wire

// ===== rtl/euler_transform_compose.sv =====
// Throughput: one beat per cycle unless rsp_stall holds it; every stage is a register,
// one rotation cell per CORDIC stage, so nothing is shared between successive beats.
// Reset: synchronous, active high; clears only the stage valid bits, the pipeline
// comes up empty and payload registers are left as they are.
`default_nettype none

module euler_transform_compose
   import etc_pkg::*;
#(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)
(
   input  wire logic                     clock,
   input  wire logic                     reset,

   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic signed [ANG_W-1:0]  req_pitch_angle,
   input  wire logic signed [ANG_W-1:0]  req_roll_angle,
   input  wire logic signed [ANG_W-1:0]  req_yaw_angle,
   input  wire logic signed [SC_W-1:0]   req_scale_x,
   input  wire logic signed [SC_W-1:0]   req_scale_y,
   input  wire logic signed [SC_W-1:0]   req_scale_z,

   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic signed [OUT_W-1:0]       rsp_c0r0,
   output logic signed [OUT_W-1:0]       rsp_c0r1,
   output logic signed [OUT_W-1:0]       rsp_c0r2,
   output logic signed [OUT_W-1:0]       rsp_c1r0,
   output logic signed [OUT_W-1:0]       rsp_c1r1,
   output logic signed [OUT_W-1:0]       rsp_c1r2,
   output logic signed [OUT_W-1:0]       rsp_c2r0,
   output logic signed [OUT_W-1:0]       rsp_c2r1,
   output logic signed [OUT_W-1:0]       rsp_c2r2
);

   // stage map:
   //   0..1                  angle wrap, quadrant split
   //   2..N+1                rotation cells
   //   N+2..N+5              round, pair and triple products, entries
   //   N+6..N+7              scale multiply, round and saturate (output register)
   localparam int ST_CELL = 2;
   localparam int ST_COL  = ST_CELL + CORDIC_STAGES;
   localparam int ST_SCL  = ST_COL + 4;
   localparam int LAT     = ST_SCL + 2;

   // ---------------------------------------------------------------
   // flow control: a stage may load when it is empty or the stage
   // after it moves, so bubbles are squeezed out while the output
   // register holds a stalled beat
   // ---------------------------------------------------------------
   logic [LAT-1:0] vld_ff, vld_in, en;

   assign en[LAT-1] = !vld_ff[LAT-1] || !rsp_stall;

   for (genvar i = 0; i < LAT - 1; i++) begin : g_en
      assign en[i] = !vld_ff[i] || en[i+1];
   end

   assign vld_in = {vld_ff[LAT-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 0; i < LAT; i++) begin
            if (en[i]) begin
               vld_ff[i] <= vld_in[i];
            end
         end
      end
   end

   assign req_stall = !en[0];
   assign rsp_valid = vld_ff[LAT-1];

   // ---------------------------------------------------------------
   // angle preparation
   // ---------------------------------------------------------------
   logic [2:0][ANG_W-1:0] angles;
   logic [2:0][SC_W-1:0]  scales;

   always_comb begin
      angles[AX_PITCH] = req_pitch_angle;
      angles[AX_ROLL]  = req_roll_angle;
      angles[AX_YAW]   = req_yaw_angle;
      scales[0]        = req_scale_x;
      scales[1]        = req_scale_y;
      scales[2]        = req_scale_z;
   end

   rot_type rot [CORDIC_STAGES+1];

   etc_angle_prep u_prep (
      .clock (clock),
      .en    (en[1:0]),
      .angle (angles),
      .scale (scales),
      .rot   (rot[0])
   );

   // ---------------------------------------------------------------
   // rotation chain: one cell per CORDIC stage, all three axes side
   //   by side, each cell hands its x/y/z to the next every cycle
   //   unless a downstream stall holds the chain
   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
      etc_cordic_cell #(
         .STAGE (g)
      ) u_cell (
         .clock (clock),
         .en    (en[ST_CELL+g]),
         .d_in  (rot[g]),
         .d_out (rot[g+1])
      );
   end

   // ---------------------------------------------------------------
   // column build
   // ---------------------------------------------------------------
   col_type col;

   etc_column u_col (
      .clock (clock),
      .en    (en[ST_COL+3:ST_COL]),
      .rot   (rot[CORDIC_STAGES]),
      .col   (col)
   );

   // ---------------------------------------------------------------
   // per-entry scaling; column k takes scale k
   // ---------------------------------------------------------------
   logic signed [OUT_W-1:0] ent_out [9];

   for (genvar j = 0; j < 9; j++) begin : g_scl
      etc_scale u_scl (
         .clock  (clock),
         .en     (en[ST_SCL+1:ST_SCL]),
         .entry  (col.m[j]),
         .scale  ($signed(col.scale[j/3])),
         .result (ent_out[j])
      );
   end

   assign rsp_c0r0 = ent_out[0];
   assign rsp_c0r1 = ent_out[1];
   assign rsp_c0r2 = ent_out[2];
   assign rsp_c1r0 = ent_out[3];
   assign rsp_c1r1 = ent_out[4];
   assign rsp_c1r2 = ent_out[5];
   assign rsp_c2r0 = ent_out[6];
   assign rsp_c2r1 = ent_out[7];
   assign rsp_c2r2 = ent_out[8];

endmodule

`default_nettype wire

// ===== tb/euler_transform_compose_tb.sv =====
`timescale 1ns / 100ps

module euler_transform_compose_tb
   import etc_pkg::*;
();

   // Checks the Euler-angle transform composer against an in-bench model of its
   // fixed-point arithmetic: CORDIC sine/cosine per axis, Z-X-Y column build,
   // per-axis Q4.12 scaling with rounding and saturation. Both channels idle and
   // stall at random, with calm stretches between.

   localparam int STAGES      = CORDIC_STAGES_DEF;
   localparam int QUIET_LIMIT = 2000;   // cycles without any accepted beat
   localparam int RANDOM_SETS = 1600;
   localparam int REPORT_MAX  = 10;

   // angle arithmetic, units of 1/64 degree
   localparam longint FULL_TURN    = 23040;
   localparam longint QUARTER_TURN = 5760;
   localparam longint CORDIC_GAIN  = 163008219;   // 0.6072529... in Q.28
   localparam longint UNIT_Q14     = 16384;
   localparam longint UNIT_Q28     = 268435456;
   localparam longint ENTRY_LIMIT  = 131072;

   // atan(2^-i) in 2^-20 degree
   localparam longint ARC_STEP [24] = '{
      47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
      234682,   117342,   58671,    29335,   14668,   7334,    3667,   1833,
      917,      458,      229,      115,     57,      29,      14,     7
   };

   // awkward angles: wrap points, quadrant edges, both ends of the field
   localparam int ANGLE_CORNERS [12] = '{
      0, 23040, -23040, 5760, 11520, 17280, -5760, 5759, 32767, -32768, -1, 1
   };

   localparam string ENTRY_NAMES [9] = '{
      "c0r0", "c0r1", "c0r2", "c1r0", "c1r1", "c1r2", "c2r0", "c2r1", "c2r2"
   };

   typedef struct packed {
      logic [ANG_W-1:0] pitch;
      logic [ANG_W-1:0] roll;
      logic [ANG_W-1:0] yaw;
      logic [SC_W-1:0]  sx;
      logic [SC_W-1:0]  sy;
      logic [SC_W-1:0]  sz;
   } angle_set_type;

   // entry [0] is c0r0, [8] is c2r2
   typedef logic [8:0][OUT_W-1:0] matrix_type;

   logic                      clock;
   logic                      reset = 1'b1;

   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic signed [ANG_W-1:0]   req_pitch_angle = '0;
   logic signed [ANG_W-1:0]   req_roll_angle = '0;
   logic signed [ANG_W-1:0]   req_yaw_angle = '0;
   logic signed [SC_W-1:0]    req_scale_x = '0;
   logic signed [SC_W-1:0]    req_scale_y = '0;
   logic signed [SC_W-1:0]    req_scale_z = '0;

   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic signed [OUT_W-1:0]   rsp_c0r0, rsp_c0r1, rsp_c0r2;
   logic signed [OUT_W-1:0]   rsp_c1r0, rsp_c1r1, rsp_c1r2;
   logic signed [OUT_W-1:0]   rsp_c2r0, rsp_c2r1, rsp_c2r2;

   matrix_type                pending_matrices [$];
   int                        fault_count = 0;
   int                        quiet_cycles = 0;
   int                        req_calm_left = 0;   // beats still to send back to back
   int                        rsp_calm_left = 0;   // results still to take without stall

   euler_transform_compose #(
      .CORDIC_STAGES (STAGES)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pitch_angle (req_pitch_angle),
      .req_roll_angle  (req_roll_angle),
      .req_yaw_angle   (req_yaw_angle),
      .req_scale_x     (req_scale_x),
      .req_scale_y     (req_scale_y),
      .req_scale_z     (req_scale_z),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_c0r0        (rsp_c0r0),
      .rsp_c0r1        (rsp_c0r1),
      .rsp_c0r2        (rsp_c0r2),
      .rsp_c1r0        (rsp_c1r0),
      .rsp_c1r1        (rsp_c1r1),
      .rsp_c1r2        (rsp_c1r2),
      .rsp_c2r0        (rsp_c2r0),
      .rsp_c2r1        (rsp_c2r1),
      .rsp_c2r2        (rsp_c2r2)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Model
   // ---------------------------------------------------------------------

   // Q1.14 sine and cosine of one angle: wrap to one turn, split off the
   // quadrant, rotate the residue through the CORDIC, round, clamp, then
   // fold the quadrant back in.
   function automatic void unit_trig(input logic [ANG_W-1:0] ang,
                                     output longint s_out, output longint c_out);
      longint     a, r, x, y, z, dx, dy, s, c;
      logic [1:0] q;
      int         i;
      a = longint'($signed(ang)) % FULL_TURN;
      if (a < 0) a += FULL_TURN;
      q = 2'(a / QUARTER_TURN);
      r = a % QUARTER_TURN;
      x = CORDIC_GAIN;
      y = 0;
      z = r * 16384;
      for (i = 0; i < STAGES && i < 24; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx;
            y += dy;
            z -= ARC_STEP[i];
         end else begin
            x += dx;
            y -= dy;
            z += ARC_STEP[i];
         end
      end
      c = (x + 8192) >>> 14;
      s = (y + 8192) >>> 14;
      c = (c > UNIT_Q14) ? UNIT_Q14 : ((c < -UNIT_Q14) ? -UNIT_Q14 : c);
      s = (s > UNIT_Q14) ? UNIT_Q14 : ((s < -UNIT_Q14) ? -UNIT_Q14 : s);
      case (q)
         QD_0: begin s_out = s;  c_out = c;  end
         QD_1: begin s_out = c;  c_out = -s; end
         QD_2: begin s_out = -s; c_out = -c; end
         default: begin s_out = -c; c_out = s; end
      endcase
   endfunction

   // Scaled rotation matrix for one angle set, entries in 14 fraction bits.
   function automatic matrix_type predict_matrix(input angle_set_type a);
      longint     sp, cp, sr, cr, sy, cy, sc, v;
      longint     col [9];
      matrix_type res;
      int         j;
      unit_trig(a.pitch, sp, cp);
      unit_trig(a.roll, sr, cr);
      unit_trig(a.yaw, sy, cy);
      // exact column terms, 42 fraction bits
      col[0] = cy * cr * UNIT_Q14 - sy * sp * sr;
      col[1] = sy * cr * UNIT_Q14 + cy * sp * sr;
      col[2] = -(cp * sr * UNIT_Q14);
      col[3] = -(sy * cp * UNIT_Q14);
      col[4] = cy * cp * UNIT_Q14;
      col[5] = sp * UNIT_Q28;
      col[6] = cy * sr * UNIT_Q14 + sy * sp * cr;
      col[7] = sy * sr * UNIT_Q14 - cy * sp * cr;
      col[8] = cp * cr * UNIT_Q14;
      for (j = 0; j < 9; j++) begin
         sc = (j < 3) ? longint'($signed(a.sx))
            : ((j < 6) ? longint'($signed(a.sy)) : longint'($signed(a.sz)));
         // 54 fraction bits down to 14, round half up, then saturate
         v = (col[j] * sc + (longint'(1) << 39)) >>> 40;
         if (v > ENTRY_LIMIT) v = ENTRY_LIMIT;
         if (v < -ENTRY_LIMIT) v = -ENTRY_LIMIT;
         res[j] = v[OUT_W-1:0];
      end
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   // Sends one angle set. Valid is left high on return so a following beat
   // with no gap goes out back to back; the model's answer is queued at the
   // edge that accepts the beat.
   task automatic send_angle_set(input angle_set_type a);
      int gap;
      if (req_calm_left > 0) begin
         req_calm_left--;
         gap = 0;
      end else begin
         if ($urandom_range(0, 49) == 0) req_calm_left = $urandom_range(20, 80);
         gap = $urandom_range(0, 14);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_pitch_angle <= a.pitch;
      req_roll_angle  <= a.roll;
      req_yaw_angle   <= a.yaw;
      req_scale_x     <= a.sx;
      req_scale_y     <= a.sy;
      req_scale_z     <= a.sz;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      pending_matrices.insert(pending_matrices.size(), predict_matrix(a));
   endtask

   // Random angle: mostly within one turn, some anywhere in the field, some
   // hugging a quadrant edge, a few at the corner angles.
   function automatic logic [ANG_W-1:0] pick_angle();
      int v;
      case ($urandom_range(0, 9)) inside
         [0:5]:   v = int'($urandom_range(0, 46080)) - 23040;
         [6:7]:   v = int'($urandom);
         8:       v = (int'($urandom_range(0, 8)) - 4) * 5760
                      + int'($urandom_range(0, 4)) - 2;
         default: v = ANGLE_CORNERS[$urandom_range(0, 11)];
      endcase
      return 16'(v);
   endfunction

   // Random scale: full range, near plus or minus one, ends, and tiny values.
   function automatic logic [SC_W-1:0] pick_scale();
      int v;
      case ($urandom_range(0, 9)) inside
         [0:5]:   v = int'($urandom);
         [6:7]:   v = ($urandom_range(0, 1) ? 4096 : -4096)
                      + int'($urandom_range(0, 16)) - 8;
         8:       v = $urandom_range(0, 1) ? 32767 : -32768;
         default: v = int'($urandom_range(0, 64)) - 32;
      endcase
      return 16'(v);
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Each axis visits every corner angle, including the wrap beyond one
   // turn and both ends of the field, with unity scale.
   task automatic test_angle_corners();
      angle_set_type a;
      int            i;
      for (i = 0; i < 12; i++) begin
         a.pitch = 16'(ANGLE_CORNERS[i]);
         a.roll  = 16'(ANGLE_CORNERS[(i + 4) % 12]);
         a.yaw   = 16'(ANGLE_CORNERS[(i + 8) % 12]);
         a.sx    = 16'd4096;
         a.sy    = 16'd4096;
         a.sz    = 16'd4096;
         send_angle_set(a);
      end
   endtask

   // Scale ends and alternating bit patterns; the largest magnitudes push
   // entries onto and past the saturation bound.
   task automatic test_scale_corners();
      localparam int SCALES [8] = '{-32768, 32767, 0, 4096, -4096, 21845, -21846, 1};
      localparam int TILTS  [8] = '{0, 2880, -2880, 8640, 0, 14400, 20160, -17280};
      angle_set_type a;
      int            i;
      for (i = 0; i < 8; i++) begin
         a.pitch = 16'(TILTS[i]);
         a.roll  = 16'(TILTS[(i + 3) % 8]);
         a.yaw   = 16'(TILTS[(i + 5) % 8]);
         a.sx    = 16'(SCALES[i]);
         a.sy    = 16'(SCALES[(i + 1) % 8]);
         a.sz    = 16'(SCALES[(i + 2) % 8]);
         send_angle_set(a);
      end
   endtask

   task automatic test_random_sets(input int count);
      angle_set_type a;
      int            n;
      for (n = 0; n < count; n++) begin
         a.pitch = pick_angle();
         a.roll  = pick_angle();
         a.yaw   = pick_angle();
         a.sx    = pick_scale();
         a.sy    = pick_scale();
         a.sz    = pick_scale();
         send_angle_set(a);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_angle_corners();
      test_scale_corners();
      test_random_sets(RANDOM_SETS);

      // all beats sent: drop valid, drain, then allow for a stray late result
      req_valid <= 1'b0;
      while (pending_matrices.size() != 0) @(posedge clock);
      repeat (STAGES + 16) @(posedge clock);

      if (fault_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // ---------------------------------------------------------------------
   // Result side
   // ---------------------------------------------------------------------

   // Stall drawn afresh before each result, with calm stretches now and then.
   initial begin : result_stall
      int pause;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (rsp_calm_left > 0) begin
            rsp_calm_left--;
            pause = 0;
         end else begin
            if ($urandom_range(0, 39) == 0) rsp_calm_left = $urandom_range(20, 80);
            pause = $urandom_range(0, 14);
         end
         if (pause > 0) begin
            rsp_stall <= 1'b1;
            repeat (pause) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
      end
   end

   // Every accepted result beat is matched against the oldest prediction.
   always @(posedge clock) begin : result_check
      matrix_type got, want;
      int         j;
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         got = {rsp_c2r2, rsp_c2r1, rsp_c2r0, rsp_c1r2, rsp_c1r1, rsp_c1r0,
                rsp_c0r2, rsp_c0r1, rsp_c0r0};
         if (pending_matrices.size() == 0) begin
            fault_count++;
            if (fault_count <= REPORT_MAX)
               $display("%0t: result beat with nothing outstanding", $realtime);
         end else begin
            want = pending_matrices.pop_front();
            for (j = 0; j < 9; j++) begin
               if (got[j] !== want[j]) begin
                  fault_count++;
                  if (fault_count <= REPORT_MAX)
                     $display("%0t: %s expected %0d, got %0d", $realtime, ENTRY_NAMES[j],
                              $signed(want[j]), $signed(got[j]));
               end
            end
         end
      end
   end

   // Watchdog: too long without a beat on either channel means a hang.
   always @(posedge clock) begin
      if ((req_valid === 1'b1 && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && rsp_stall === 1'b0))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

endmodule

// ===== euler_transform_compose.f =====
rtl/etc_pkg.sv
rtl/etc_angle_prep.sv
rtl/etc_cordic_cell.sv
rtl/etc_column.sv
rtl/etc_scale.sv
rtl/euler_transform_compose.sv
tb/euler_transform_compose_tb.sv
